@@ hw/rtl/i2cm_pkg.sv @@
// Shared types and constants of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

   // Command codes carried on the input channel.
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_SEND  = 3'd3;
   localparam logic [2:0] CMD_WAIT  = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   // Configuration register indexes.
   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_TIMEOUT  = 1'b1;

   localparam int unsigned CSR_DATA_WIDTH = 10;

   localparam logic [9:0] TICKS_PER_US_RESET = 10'd1;
   localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Input item.
   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   // Result item.
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } rsp_type;

   // Command class decided by the front end.
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_SEND  = 3'd3,
      OP_WAIT  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   // One classified tick waiting for the sequencer.
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } tick_type;

   // Live configuration handed to the sequencer.
   typedef struct packed {
      logic [9:0] ticks_per_us;
      logic [7:0] ack_timeout;
   } cfg_type;

   // Pin sequencer phases.
   typedef enum logic [20:0] {
      PH_IDLE = 21'h000001,
      PH_ST0  = 21'h000002,
      PH_ST1  = 21'h000004,
      PH_ST2  = 21'h000008,
      PH_SP0  = 21'h000010,
      PH_SP1  = 21'h000020,
      PH_SP2  = 21'h000040,
      PH_WA0  = 21'h000080,
      PH_WA1  = 21'h000100,
      PH_WA2  = 21'h000200,
      PH_TX0  = 21'h000400,
      PH_TX1  = 21'h000800,
      PH_TX2  = 21'h001000,
      PH_TX3  = 21'h002000,
      PH_RX0  = 21'h004000,
      PH_RX1  = 21'h008000,
      PH_RX2  = 21'h010000,
      PH_RX3  = 21'h020000,
      PH_RX4  = 21'h040000,
      PH_RX5  = 21'h080000,
      PH_END  = 21'h100000
   } phase_type;

endpackage

@@ hw/rtl/i2cm_front.sv @@
// Front end: accepts ticks and classifies their commands.
`timescale 1ns / 1ps

module i2cm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cm_pkg::req_type   req_data,
   input  logic                queue_full,
   output logic                push,
   output i2cm_pkg::tick_type  push_item
);

   i2cm_pkg::op_type op;

   always_comb begin
      unique case (req_data.cmd)
         i2cm_pkg::CMD_START: op = i2cm_pkg::OP_START;
         i2cm_pkg::CMD_STOP:  op = i2cm_pkg::OP_STOP;
         i2cm_pkg::CMD_SEND:  op = i2cm_pkg::OP_SEND;
         i2cm_pkg::CMD_WAIT:  op = i2cm_pkg::OP_WAIT;
         i2cm_pkg::CMD_READ:  op = i2cm_pkg::OP_READ;
         default:             op = i2cm_pkg::OP_NONE;
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   assign push_item.op       = op;
   assign push_item.tx_byte  = req_data.tx_byte;
   assign push_item.send_ack = req_data.send_ack;
   assign push_item.sda_in   = req_data.sda_in;

   // Every accepted tick must reach the queue.
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> push)
      else $error("accepted item not queued");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("push into full queue");

   a_class_none: assert property (@(posedge clock) disable iff (reset)
      (push && (req_data.cmd == i2cm_pkg::CMD_NONE || req_data.cmd > i2cm_pkg::CMD_READ))
         |-> (push_item.op == i2cm_pkg::OP_NONE))
      else $error("unknown command not classified as none");

endmodule

@@ hw/rtl/i2cm_queue.sv @@
// Short first-in first-out queue of classified ticks.
`timescale 1ns / 1ps

module i2cm_queue #(
   parameter int unsigned Depth = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cm_pkg::tick_type  push_item,
   input  logic                pop,
   output i2cm_pkg::tick_type  head_item,
   output logic                full,
   output logic                empty
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   i2cm_pkg::tick_type      slots_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full      = (count_ff == FullCount);
   assign empty     = (count_ff == '0);
   assign head_item = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a push");

endmodule

@@ hw/rtl/i2cm_seq.sv @@
// Back end: bus pin sequencer with its result register.
`timescale 1ns / 1ps

module i2cm_seq (
   input  logic                clock,
   input  logic                reset,
   input  i2cm_pkg::cfg_type   cfg,
   input  i2cm_pkg::tick_type  head_item,
   input  logic                queue_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cm_pkg::rsp_type   rsp_data
);

   // A tick can chain a few zero-hold steps; two suffice, one more is spare.
   localparam int unsigned StepsPerTick = 3;

   typedef struct packed {
      i2cm_pkg::phase_type phase;
      logic [3:0]          bit_index;
      logic [7:0]          shift;
      logic [11:0]         delay;
      logic [7:0]          poll;
      logic                scl;
      logic                sda;
      logic                sda_oe;
      logic                ack_err;
      logic                ack_choice;
      logic [7:0]          rx_last;
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic               done_tick;
   logic               rsp_valid_ff;
   i2cm_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic [9:0]         tick_unit;
   logic [11:0]        hold_1us;
   logic [11:0]        hold_2us;

   // A zero tick rate counts as one tick per microsecond.
   assign tick_unit = (cfg.ticks_per_us == '0) ? 10'd1 : cfg.ticks_per_us;
   assign hold_1us  = {2'b00, tick_unit};
   assign hold_2us  = {1'b0, tick_unit, 1'b0};

   function automatic seq_state_type run_step(
      input seq_state_type s,
      input logic          sda_in,
      input logic [11:0]   h1,
      input logic [11:0]   h2,
      input logic [7:0]    timeout
   );
      seq_state_type r;
      logic [3:0]    next_bit;
      logic [7:0]    next_shift;
      r          = s;
      next_bit   = s.bit_index + 4'd1;
      next_shift = {s.shift[6:0], sda_in};
      unique case (s.phase)
         i2cm_pkg::PH_ST0: begin
            r.sda_oe = 1'b1; r.sda = 1'b1; r.scl = 1'b1;
            r.delay = h2; r.phase = i2cm_pkg::PH_ST1;
         end
         i2cm_pkg::PH_ST1: begin
            r.sda = 1'b0; r.delay = h2; r.phase = i2cm_pkg::PH_ST2;
         end
         i2cm_pkg::PH_ST2: begin
            r.scl = 1'b0; r.delay = '0; r.phase = i2cm_pkg::PH_END;
         end
         i2cm_pkg::PH_SP0: begin
            r.sda_oe = 1'b1; r.scl = 1'b0; r.sda = 1'b0;
            r.delay = h2; r.phase = i2cm_pkg::PH_SP1;
         end
         i2cm_pkg::PH_SP1: begin
            r.scl = 1'b1; r.delay = h2; r.phase = i2cm_pkg::PH_SP2;
         end
         i2cm_pkg::PH_SP2: begin
            r.sda = 1'b1; r.delay = h2; r.phase = i2cm_pkg::PH_END;
         end
         i2cm_pkg::PH_WA0: begin
            r.sda_oe = 1'b0; r.sda = 1'b1; r.poll = '0;
            r.delay = h1; r.phase = i2cm_pkg::PH_WA1;
         end
         i2cm_pkg::PH_WA1: begin
            r.scl = 1'b1; r.delay = h1; r.phase = i2cm_pkg::PH_WA2;
         end
         i2cm_pkg::PH_WA2: begin
            if (!sda_in) begin
               r.scl = 1'b0; r.ack_err = 1'b0; r.delay = '0;
               r.phase = i2cm_pkg::PH_END;
            end else if (s.poll >= timeout) begin
               r.ack_err = 1'b1; r.delay = '0; r.phase = i2cm_pkg::PH_SP0;
            end else begin
               r.poll = s.poll + 8'd1; r.delay = 12'd1;
            end
         end
         i2cm_pkg::PH_TX0: begin
            r.sda_oe = 1'b1; r.scl = 1'b0; r.bit_index = '0;
            r.delay = '0; r.phase = i2cm_pkg::PH_TX1;
         end
         i2cm_pkg::PH_TX1: begin
            r.sda = s.shift[7]; r.shift = {s.shift[6:0], 1'b0};
            r.delay = h2; r.phase = i2cm_pkg::PH_TX2;
         end
         i2cm_pkg::PH_TX2: begin
            r.scl = 1'b1; r.delay = h2; r.phase = i2cm_pkg::PH_TX3;
         end
         i2cm_pkg::PH_TX3: begin
            r.scl = 1'b0; r.bit_index = next_bit; r.delay = h2;
            r.phase = (next_bit < 4'd8) ? i2cm_pkg::PH_TX1 : i2cm_pkg::PH_END;
         end
         i2cm_pkg::PH_RX0: begin
            r.sda_oe = 1'b0; r.bit_index = '0; r.shift = '0;
            r.delay = '0; r.phase = i2cm_pkg::PH_RX1;
         end
         i2cm_pkg::PH_RX1: begin
            r.scl = 1'b0; r.delay = h2; r.phase = i2cm_pkg::PH_RX2;
         end
         i2cm_pkg::PH_RX2: begin
            r.scl = 1'b1; r.shift = next_shift; r.bit_index = next_bit;
            r.delay = h1;
            if (next_bit < 4'd8) begin
               r.phase = i2cm_pkg::PH_RX1;
            end else begin
               r.rx_last = next_shift; r.phase = i2cm_pkg::PH_RX3;
            end
         end
         i2cm_pkg::PH_RX3: begin
            r.scl = 1'b0; r.sda_oe = 1'b1; r.sda = !s.ack_choice;
            r.delay = h2; r.phase = i2cm_pkg::PH_RX4;
         end
         i2cm_pkg::PH_RX4: begin
            r.scl = 1'b1; r.delay = h2; r.phase = i2cm_pkg::PH_RX5;
         end
         i2cm_pkg::PH_RX5: begin
            r.scl = 1'b0; r.delay = '0; r.phase = i2cm_pkg::PH_END;
         end
         default: begin
            r.phase = i2cm_pkg::PH_END; r.delay = '0;
         end
      endcase
      return r;
   endfunction

   // The sequencer takes a tick whenever the result register is free or draining.
   assign pop = !queue_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      seq_state_type st;
      st        = state_ff;
      done_tick = 1'b0;
      if (st.phase == i2cm_pkg::PH_IDLE) begin
         case (head_item.op)
            i2cm_pkg::OP_START: begin
               st.phase = i2cm_pkg::PH_ST0; st.delay = '0;
            end
            i2cm_pkg::OP_STOP: begin
               st.phase = i2cm_pkg::PH_SP0; st.delay = '0;
            end
            i2cm_pkg::OP_SEND: begin
               st.phase = i2cm_pkg::PH_TX0; st.delay = '0;
               st.shift = head_item.tx_byte;
            end
            i2cm_pkg::OP_WAIT: begin
               st.phase = i2cm_pkg::PH_WA0; st.delay = '0;
            end
            i2cm_pkg::OP_READ: begin
               st.phase = i2cm_pkg::PH_RX0; st.delay = '0;
               st.ack_choice = head_item.send_ack;
            end
            default: begin
            end
         endcase
      end else if (st.delay != '0) begin
         st.delay = st.delay - 12'd1;
      end
      for (int i = 0; i < StepsPerTick; i++) begin
         if (st.phase != i2cm_pkg::PH_IDLE && st.delay == '0) begin
            if (st.phase == i2cm_pkg::PH_END) begin
               st.phase  = i2cm_pkg::PH_IDLE;
               done_tick = 1'b1;
            end else begin
               st = run_step(st, head_item.sda_in, hold_1us, hold_2us, cfg.ack_timeout);
            end
         end
      end
      state_in = st;
   end

   always_comb begin
      rsp_data_in.scl_out    = state_in.scl;
      rsp_data_in.sda_out    = state_in.sda;
      rsp_data_in.sda_drive  = state_in.sda_oe;
      rsp_data_in.busy_res   = (state_in.phase != i2cm_pkg::PH_IDLE);
      rsp_data_in.done_res   = done_tick;
      rsp_data_in.rx_byte    = state_in.rx_last;
      rsp_data_in.ack_failed = state_in.ack_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= i2cm_pkg::PH_IDLE;
         state_ff.bit_index  <= '0;
         state_ff.shift      <= '0;
         state_ff.delay      <= '0;
         state_ff.poll       <= '0;
         state_ff.scl        <= 1'b1;
         state_ff.sda        <= 1'b1;
         state_ff.sda_oe     <= 1'b1;
         state_ff.ack_err    <= 1'b0;
         state_ff.ack_choice <= 1'b0;
         state_ff.rx_last    <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (pop) begin
            state_ff <= state_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (pop && state_ff.phase == i2cm_pkg::PH_IDLE && head_item.op == i2cm_pkg::OP_START)
         |=> (state_ff.phase != i2cm_pkg::PH_IDLE))
      else $error("start command did not leave idle");

   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == i2cm_pkg::PH_IDLE) |-> (state_ff.delay == '0))
      else $error("hold pending while idle");

   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index <= 4'd8)
      else $error("bit index beyond eight");

   a_poll_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == i2cm_pkg::PH_WA2) |-> (state_ff.poll <= cfg.ack_timeout))
      else $error("ack poll count beyond timeout");

   a_done_reported: assert property (@(posedge clock) disable iff (reset)
      (pop && done_tick) |=> (rsp_valid_ff && rsp_data_ff.done_res && !rsp_data_ff.busy_res))
      else $error("completion not reported as idle");

endmodule

@@ hw/rtl/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: front end, tick queue, sequencer, registers.
`timescale 1ns / 1ps

// This engine bit-bangs an I2C master on SCL and SDA. Every input item is one
// time tick of the bus sequencer and produces exactly one result item holding
// the pin levels, SDA direction, busy and done flags, the last received byte
// and the acknowledge failure flag. While the engine is idle an item may carry
// a command (start, stop, send a byte, wait for acknowledge, read a byte and
// answer ACK or NACK); commands that arrive while it is busy are ignored, as
// are unknown codes. Each timed pin step is held for a number of microseconds,
// one microsecond being ticks_per_us items. The block sustains one item per
// clock cycle while results are taken: a front end classifies each item and
// places it in a short queue, and the sequencer retires one queued item per
// cycle into a result register, so neither side stalls the other while the
// queue has room. With no stalls an accepted item is written into a queue
// slot, and its result into the result register, which offers it on the
// output. Configuration registers are written through the plain write port and
// should only change while no command is in flight.

module i2c_master_bit_engine #(
   parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  i2cm_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output i2cm_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic                                  csr_index,
   input  logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   i2cm_pkg::cfg_type   cfg_ff;
   i2cm_pkg::tick_type  push_item;
   i2cm_pkg::tick_type  head_item;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;

   // Configuration registers; a write lands on the edge its enable is high.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us <= i2cm_pkg::TICKS_PER_US_RESET;
         cfg_ff.ack_timeout  <= i2cm_pkg::ACK_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            i2cm_pkg::CSR_TICKS_PER_US: cfg_ff.ticks_per_us <= csr_wdata[9:0];
            i2cm_pkg::CSR_ACK_TIMEOUT:  cfg_ff.ack_timeout  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // The front end decodes the command and pushes every accepted item.
   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // The queue decouples acceptance from the sequencer and the output stall.
   i2cm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // The sequencer walks the pin steps, one item per cycle while results are taken.
   i2cm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_item   (head_item),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
